// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational invariant
`define ITDA_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// next-cycle implication
`define ITDA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg
// Types and constants of the integer to decimal text converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int MAG_W     = 30;               // magnitude bits below 1e9
  localparam int STEP_BITS = 5;                // dabble steps per stage
  localparam int NUM_ST    = MAG_W / STEP_BITS;

  localparam logic [5:0] CH_NUL   = 6'd0;
  localparam logic [5:0] CH_PLUS  = 6'd43;
  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_ZERO  = 6'd48;

  typedef struct packed {
    logic v;
    logic neg;
    logic plus;
    logic big;
  } ctl_t;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < n; i++) begin
      p = 32'(p * 32'd10);
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/int_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_value / in_force_plus with start; the beat is taken at a
//   clock edge where start is high and busy is low.
//   Output: out_valid marks each character beat for one cycle: optional
//   sign, digits msd first without leading zeros, then NUL with out_last.
//   out_char_count (sign + digits) rides on every beat of the run.
//   Magnitudes of 10^MAX_DIGITS or more (and the most negative integer)
//   give only the sign, if any, and the terminator.
// Pipeline: an accepted item passes the input register, 6 dabble
//   stages and the digit count stage before the emitter puts out its
//   first character.
// Flow: the emitter puts out one run of char_count + 1 beats per item;
//   the stages ahead of it hold up to 8 more items, and busy rises,
//   holding them all, while the digit count stage waits on the emitter.
// Reset: rst_n low for one edge empties every stage and the emitter.
// The receiver cannot stall; every out_valid beat is consumed as shown.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module int_to_decimal_ascii_top #(
  parameter int MAX_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic               in_force_plus,
  output logic               out_valid,
  output logic [5:0]         out_character,
  output logic               out_last,
  output logic [3:0]         out_char_count
);

  localparam int          DIG_W = 4 * MAX_DIGITS;
  localparam logic [31:0] LIMIT = itda_pkg::pow10(MAX_DIGITS);
  localparam int          NST   = itda_pkg::NUM_ST;
  localparam int          MW    = itda_pkg::MAG_W;

  logic                   accept, stall, load, emit_done;

  // input stage
  itda_pkg::ctl_t         s0_ctl_r, s0_ctl_nxt;
  logic [MW-1:0]          s0_bin_r, s0_bin_nxt;
  logic [31:0]            mag;

  // dabble chain
  itda_pkg::ctl_t         ch_ctl [NST+1];
  logic [MW-1:0]          ch_bin [NST+1];
  logic [DIG_W-1:0]       ch_bcd [NST+1];

  // digit count stage
  itda_pkg::ctl_t         cs_ctl_r;
  logic [3:0]             cs_total_r, cs_total_nxt, nd_nxt;
  logic [DIG_W-1:0]       cs_dig_r, cs_dig_nxt;

  // emitter
  logic                   em_act_r;
  logic [3:0]             em_cnt_r, em_total_r;
  logic                   em_sign_r;
  logic [5:0]             em_sign_ch_r;
  logic [DIG_W-1:0]       em_dig_r;

  assign emit_done = em_act_r && (em_cnt_r == 4'd1);
  assign stall     = cs_ctl_r.v && em_act_r && !emit_done;
  assign load      = cs_ctl_r.v && !stall;
  assign busy      = stall;
  assign accept    = start && !busy;

  always_comb begin
    mag              = in_value[31] ? (~in_value + 32'd1) : in_value;
    s0_ctl_nxt.v     = accept;
    s0_ctl_nxt.neg   = in_value[31];
    s0_ctl_nxt.plus  = in_force_plus;
    s0_ctl_nxt.big   = (mag >= LIMIT);
    s0_bin_nxt       = s0_ctl_nxt.big ? '0 : mag[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
    end else if (!stall) begin
      s0_ctl_r <= s0_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s0_bin_r <= s0_bin_nxt;
    end
  end

  assign ch_ctl[0] = s0_ctl_r;
  assign ch_bin[0] = s0_bin_r;
  assign ch_bcd[0] = '0;

  for (genvar g = 0; g < NST; g++) begin : g_dab
    itda_dabble #(
      .DIG_W (DIG_W)
    ) u_dab (
      .clk   (clk),
      .rst_n (rst_n),
      .stall (stall),
      .ctl_i (ch_ctl[g]),
      .bin_i (ch_bin[g]),
      .bcd_i (ch_bcd[g]),
      .ctl_o (ch_ctl[g+1]),
      .bin_o (ch_bin[g+1]),
      .bcd_o (ch_bcd[g+1])
    );
  end

  // digit count and left alignment of the msd
  always_comb begin
    nd_nxt = 4'd1;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (ch_bcd[NST][4*i +: 4] != 4'd0) begin
        nd_nxt = 4'(i + 1);
      end
    end
    if (ch_ctl[NST].big) begin
      nd_nxt = 4'd0;
    end
    cs_dig_nxt   = ch_bcd[NST] << (4 * (MAX_DIGITS - int'(nd_nxt)));
    cs_total_nxt = nd_nxt + {3'd0, ch_ctl[NST].neg | ch_ctl[NST].plus};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_ctl_r <= '0;
    end else if (!stall) begin
      cs_ctl_r <= ch_ctl[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      cs_dig_r   <= cs_dig_nxt;
      cs_total_r <= cs_total_nxt;
    end
  end

  // emitter: em_cnt_r counts beats left, terminator included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_act_r <= 1'b0;
      em_cnt_r <= 4'd0;
    end else if (load) begin
      em_act_r <= 1'b1;
      em_cnt_r <= cs_total_r + 4'd1;
    end else if (em_act_r) begin
      em_act_r <= !emit_done;
      em_cnt_r <= em_cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      em_total_r   <= cs_total_r;
      em_sign_r    <= cs_ctl_r.neg | cs_ctl_r.plus;
      em_sign_ch_r <= cs_ctl_r.neg ? itda_pkg::CH_MINUS : itda_pkg::CH_PLUS;
      em_dig_r     <= cs_dig_r;
    end else if (em_act_r) begin
      if (em_sign_r) begin
        em_sign_r <= 1'b0;
      end else begin
        em_dig_r <= em_dig_r << 4;
      end
    end
  end

  always_comb begin
    out_valid      = em_act_r;
    out_char_count = em_total_r;
    out_last       = (em_cnt_r == 4'd1);
    if (out_last) begin
      out_character = itda_pkg::CH_NUL;
    end else if (em_sign_r) begin
      out_character = em_sign_ch_r;
    end else begin
      out_character = itda_pkg::CH_ZERO + {2'd0, em_dig_r[DIG_W-1 -: 4]};
    end
  end

  `ITDA_NEXT(a_run_ends, emit_done && !load, !out_valid, "beat after terminator")
  `ITDA_NEXT(a_stall_holds, stall, $stable(cs_total_r) && cs_ctl_r.v, "stalled item moved")
  `ITDA_CHECK(a_total_nonzero, !out_valid || out_last || (out_char_count != 4'd0), "zero count")

endmodule

// ===== rtl/core/itda_dabble.sv =====
// ----------------------------------------------------------------------------
// itda_dabble
// One pipeline stage of shift-add-3 binary to BCD conversion.
// ----------------------------------------------------------------------------
module itda_dabble #(
  parameter int DIG_W = 36
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        stall,
  input  itda_pkg::ctl_t              ctl_i,
  input  logic [itda_pkg::MAG_W-1:0]  bin_i,
  input  logic [DIG_W-1:0]            bcd_i,
  output itda_pkg::ctl_t              ctl_o,
  output logic [itda_pkg::MAG_W-1:0]  bin_o,
  output logic [DIG_W-1:0]            bcd_o
);

  itda_pkg::ctl_t                    ctl_r;
  logic [itda_pkg::MAG_W-1:0]        bin_r, bin_nxt;
  logic [DIG_W-1:0]                  bcd_r, bcd_nxt;

  always_comb begin
    bin_nxt = bin_i;
    bcd_nxt = bcd_i;
    for (int s = 0; s < itda_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < DIG_W / 4; d++) begin
        if (bcd_nxt[4*d +: 4] >= 4'd5) begin
          bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt[DIG_W-2:0], bin_nxt, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (!stall) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign bin_o = bin_r;
  assign bcd_o = bcd_r;

endmodule

// ===== tb/sv/int_to_decimal_ascii_top_tb.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top_tb
// Self-checking bench for the signed integer to decimal text converter.
// A short table of corner values runs first: zero, the extremes, the
// too-large magnitudes and the forced plus sign. Where the text is obvious
// it is written out in the table, and the other rows use the text model.
// Random values with spread digit counts follow. Items are sent in bursts
// with random gaps. Every character beat is checked against the queue of
// expected beats.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_top_tb;

  localparam int          NUM_RANDOM  = 128;
  localparam logic [31:0] DIGIT_LIMIT = 32'd1000000000;

  typedef struct {
    logic [5:0] ch;
    logic       last;
    logic [3:0] total;
  } text_beat_t;

  typedef struct {
    logic [31:0] value;
    logic        plus;
    bit          typed;
    string       text;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_value;
  logic               in_force_plus;
  logic               out_valid;
  logic [5:0]         out_character;
  logic               out_last;
  logic [3:0]         out_char_count;

  text_beat_t text_q[$];
  int         fails = 0;
  int         burst_left = 1;

  stim_row_t stim_rows[22] = '{
    '{32'd0,            1'b0, 1'b1, "0"},
    '{32'd0,            1'b1, 1'b1, "+0"},
    '{32'h8000_0000,    1'b0, 1'b1, "-"},
    '{32'h8000_0000,    1'b1, 1'b1, "-"},
    '{32'h7FFF_FFFF,    1'b0, 1'b1, ""},
    '{32'h7FFF_FFFF,    1'b1, 1'b1, "+"},
    '{32'd1000000000,   1'b0, 1'b1, ""},
    '{-32'sd1000000000, 1'b0, 1'b1, "-"},
    '{32'd999999999,    1'b1, 1'b1, "+999999999"},
    '{-32'sd999999999,  1'b0, 1'b1, "-999999999"},
    '{32'd1,            1'b0, 1'b1, "1"},
    '{32'hFFFF_FFFF,    1'b1, 1'b1, "-1"},
    '{32'd9,            1'b0, 1'b0, ""},
    '{32'd10,           1'b1, 1'b0, ""},
    '{32'd99,           1'b0, 1'b0, ""},
    '{32'd100,          1'b1, 1'b0, ""},
    '{32'd12345,        1'b0, 1'b0, ""},
    '{-32'sd9876543,    1'b1, 1'b0, ""},
    '{32'h5555_5555,    1'b1, 1'b0, ""},
    '{32'hAAAA_AAAA,    1'b0, 1'b0, ""},
    '{32'd123456789,    1'b0, 1'b0, ""},
    '{-32'sd100000000,  1'b1, 1'b0, ""}
  };

  int_to_decimal_ascii_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_force_plus  (in_force_plus),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  function automatic void push_beat(logic [5:0] ch, logic last, int unsigned total);
    text_beat_t b;
    b.ch    = ch;
    b.last  = last;
    b.total = 4'(total);
    text_q.push_back(b);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_beat(6'(s[i]), 1'b0, s.len());
    end
    push_beat(itda_pkg::CH_NUL, 1'b1, s.len());
  endfunction

  function automatic void spell_decimal(logic [31:0] v, logic plus);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  dg[10];
    int unsigned nd;
    int unsigned total;
    neg = v[31];
    mag = neg ? 32'(-v) : v;
    nd  = 0;
    if (mag < DIGIT_LIMIT) begin
      do begin
        dg[nd] = 4'(mag % 32'd10);
        mag    = mag / 32'd10;
        nd++;
      end while (mag != 0);
    end
    total = nd + ((neg || plus) ? 1 : 0);
    if (neg) begin
      push_beat(itda_pkg::CH_MINUS, 1'b0, total);
    end else if (plus) begin
      push_beat(itda_pkg::CH_PLUS, 1'b0, total);
    end
    for (int i = nd; i > 0; i--) begin
      push_beat(itda_pkg::CH_ZERO + 6'(dg[i-1]), 1'b0, total);
    end
    push_beat(itda_pkg::CH_NUL, 1'b1, total);
  endfunction

  // spread over digit counts, with values hugging powers of ten
  function automatic logic [31:0] pick_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned m;
    int unsigned     nd;
    logic [31:0]     v;
    nd = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < nd; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (hi > 64'd2147483648) begin
      hi = 64'd2147483648;
    end
    if (nd == 1) begin
      lo = 0;
    end
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: m = (nd == 1) ? longint'($urandom_range(0, 2)) : lo + $urandom_range(0, 2) - 1;
      default: m = lo + ($urandom() % (hi - lo + 1));
    endcase
    v = m[31:0];
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v, input logic p);
    start         <= 1'b1;
    in_value      <= v;
    in_force_plus <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic pace();
    int unsigned gap;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : drive
    logic [31:0] v;
    logic        p;
    int          waited;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_value      <= '0;
    in_force_plus <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_value(stim_rows[i].value, stim_rows[i].plus);
      if (stim_rows[i].typed) begin
        queue_text(stim_rows[i].text);
      end else begin
        spell_decimal(stim_rows[i].value, stim_rows[i].plus);
      end
      pace();
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      v = pick_value();
      p = 1'($urandom_range(0, 1));
      send_value(v, p);
      spell_decimal(v, p);
      pace();
    end
    start <= 1'b0;

    waited = 0;
    while (text_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (fails == 0 && text_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : watch_text
    text_beat_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got ch=%0d last=%0b count=%0d",
                 $time, out_character, out_last, out_char_count);
        fails++;
      end else begin
        want = text_q.pop_front();
        if (out_character !== want.ch) begin
          $display("%0t: character mismatch, expected %0d, got %0d",
                   $time, want.ch, out_character);
          fails++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, out_last);
          fails++;
        end
        if (out_char_count !== want.total) begin
          $display("%0t: char count mismatch, expected %0d, got %0d",
                   $time, want.total, out_char_count);
          fails++;
        end
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/itda_pkg.sv
rtl/core/itda_dabble.sv
rtl/core/int_to_decimal_ascii_top.sv
tb/sv/int_to_decimal_ascii_top_tb.sv
